[hdl/ctq_pkg.sv]
package ctq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int HANDLE_W = 16;
  localparam int CODE_W   = 8;
  localparam int DESC_W   = 64;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(DEPTH);

  localparam logic [CODE_W-1:0] LONG_CODE_A = 8'd5;
  localparam logic [CODE_W-1:0] LONG_CODE_B = 8'd6;

  localparam int               PADDR_W         = 3;
  localparam logic             REG_QUEUE_LIMIT = 1'b0;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic apply;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic is_long(input logic [CODE_W-1:0] code);
    return (code == LONG_CODE_A) || (code == LONG_CODE_B);
  endfunction

endpackage

[hdl/ctq_ctrl.sv]
module ctq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctq_pkg::dp_stat_t stat,
  output ctq_pkg::ctl_cmd_t cmd
);

  ctq_pkg::ctl_state_t state_r;
  ctq_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ctq_pkg::S_SEARCH;
      end
      ctq_pkg::S_SEARCH: begin
        state_nxt = ctq_pkg::S_APPLY;
      end
      ctq_pkg::S_APPLY: begin
        if (stat.out_free) state_nxt = ctq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ctq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.search  = 1'b0;
    cmd.apply   = 1'b0;
    case (state_r)
      ctq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ctq_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
      end
      ctq_pkg::S_APPLY: begin
        cmd.apply = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/ctq_datapath.sv]
module ctq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctq_pkg::ctl_cmd_t                   cmd,
  output ctq_pkg::dp_stat_t                   stat,
  input  logic [ctq_pkg::LIMIT_W-1:0]         queue_limit,
  input  logic                                in_mode,
  input  logic                                in_requester_is_short,
  input  logic [ctq_pkg::HANDLE_W-1:0]        in_conn_handle_in,
  input  logic [ctq_pkg::CODE_W-1:0]          in_command_code_in,
  input  logic [ctq_pkg::DESC_W-1:0]          in_descriptor_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [ctq_pkg::HANDLE_W-1:0]        out_conn_handle_out,
  output logic [ctq_pkg::CODE_W-1:0]          out_command_code_out,
  output logic [ctq_pkg::DESC_W-1:0]          out_descriptor_out,
  output logic [ctq_pkg::CNT_W-1:0]           out_task_count,
  output logic [ctq_pkg::CNT_W-1:0]           out_short_count
);

  logic [ctq_pkg::HANDLE_W-1:0] handle_r [ctq_pkg::DEPTH];
  logic [ctq_pkg::CODE_W-1:0]   code_r   [ctq_pkg::DEPTH];
  logic [ctq_pkg::DESC_W-1:0]   desc_r   [ctq_pkg::DEPTH];
  logic [ctq_pkg::DEPTH-1:0]    long_r;

  logic [ctq_pkg::CNT_W-1:0]    held_r;
  logic [ctq_pkg::CNT_W-1:0]    held_nxt;
  logic [ctq_pkg::CNT_W-1:0]    short_r;
  logic [ctq_pkg::CNT_W-1:0]    short_nxt;

  logic                         mode_r;
  logic                         want_short_r;
  logic [ctq_pkg::HANDLE_W-1:0] hin_r;
  logic [ctq_pkg::CODE_W-1:0]   cin_r;
  logic [ctq_pkg::DESC_W-1:0]   din_r;

  logic [ctq_pkg::IDX_W-1:0]    pos_r;
  logic [ctq_pkg::IDX_W-1:0]    pos_nxt;
  logic                         found_r;
  logic                         found_nxt;

  logic                         out_valid_r;
  ctq_pkg::status_t             status_r;
  ctq_pkg::status_t             status_nxt;
  logic [ctq_pkg::HANDLE_W-1:0] hout_r;
  logic [ctq_pkg::HANDLE_W-1:0] hout_nxt;
  logic [ctq_pkg::CODE_W-1:0]   cout_r;
  logic [ctq_pkg::CODE_W-1:0]   cout_nxt;
  logic [ctq_pkg::DESC_W-1:0]   dout_r;
  logic [ctq_pkg::DESC_W-1:0]   dout_nxt;
  logic [ctq_pkg::CNT_W-1:0]    tcnt_r;
  logic [ctq_pkg::CNT_W-1:0]    scnt_r;

  logic [ctq_pkg::DEPTH-1:0]    occ;
  logic [ctq_pkg::DEPTH-1:0]    cand;
  logic [ctq_pkg::LIMIT_W-1:0]  limit_eff;
  logic                         full;
  logic                         do_enq;
  logic                         do_deq;

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r       <= in_mode;
      want_short_r <= in_requester_is_short;
      hin_r        <= in_conn_handle_in;
      cin_r        <= in_command_code_in;
      din_r        <= in_descriptor_in;
    end
  end

  // Find the oldest task of the requested class; a long request with no long task takes the oldest task.
  always_comb begin
    for (int i = 0; i < ctq_pkg::DEPTH; i++) begin
      occ[i] = ctq_pkg::CNT_W'(i) < held_r;
    end
    cand      = want_short_r ? (occ & ~long_r) : (occ & long_r);
    pos_nxt   = '0;
    found_nxt = 1'b0;
    for (int i = ctq_pkg::DEPTH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos_nxt   = ctq_pkg::IDX_W'(i);
        found_nxt = 1'b1;
      end
    end
    if (!found_nxt && !want_short_r && held_r != '0) begin
      pos_nxt   = '0;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
    end
  end

  assign limit_eff = (queue_limit > ctq_pkg::LIMIT_W'(ctq_pkg::DEPTH)) ?
                     ctq_pkg::LIMIT_W'(ctq_pkg::DEPTH) : queue_limit;
  assign full      = (held_r >= ctq_pkg::CNT_W'(limit_eff)) ||
                     (held_r >= ctq_pkg::CNT_W'(ctq_pkg::DEPTH));
  assign do_enq    = cmd.apply && (mode_r == ctq_pkg::MODE_ENQUEUE) && !full;
  assign do_deq    = cmd.apply && (mode_r == ctq_pkg::MODE_DEQUEUE) && found_r;

  always_comb begin
    held_nxt   = held_r;
    short_nxt  = short_r;
    status_nxt = ctq_pkg::ST_DONE;
    hout_nxt   = '0;
    cout_nxt   = '0;
    dout_nxt   = '0;
    if (mode_r == ctq_pkg::MODE_ENQUEUE) begin
      if (full) begin
        status_nxt = ctq_pkg::ST_FULL;
      end else begin
        held_nxt = held_r + 1'b1;
        if (!ctq_pkg::is_long(cin_r)) short_nxt = short_r + 1'b1;
      end
    end else if (!found_r) begin
      status_nxt = ctq_pkg::ST_EMPTY;
    end else begin
      hout_nxt = handle_r[pos_r];
      cout_nxt = code_r[pos_r];
      dout_nxt = desc_r[pos_r];
      held_nxt = held_r - 1'b1;
      if (!long_r[pos_r] && short_r != '0) short_nxt = short_r - 1'b1;
    end
  end

  // Close the gap on removal; append at the tail on insertion.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ctq_pkg::DEPTH - 1; i++) begin
      if (do_deq && ctq_pkg::IDX_W'(i) >= pos_r) begin
        handle_r[i] <= handle_r[i+1];
        code_r[i]   <= code_r[i+1];
        desc_r[i]   <= desc_r[i+1];
        long_r[i]   <= long_r[i+1];
      end
    end
    if (do_enq) begin
      handle_r[held_r[ctq_pkg::IDX_W-1:0]] <= hin_r;
      code_r[held_r[ctq_pkg::IDX_W-1:0]]   <= cin_r;
      desc_r[held_r[ctq_pkg::IDX_W-1:0]]   <= din_r;
      long_r[held_r[ctq_pkg::IDX_W-1:0]]   <= ctq_pkg::is_long(cin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      short_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        held_r      <= held_nxt;
        short_r     <= short_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r <= status_nxt;
      hout_r   <= hout_nxt;
      cout_r   <= cout_nxt;
      dout_r   <= dout_nxt;
      tcnt_r   <= held_nxt;
      scnt_r   <= short_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_conn_handle_out  = hout_r;
  assign out_command_code_out = cout_r;
  assign out_descriptor_out   = dout_r;
  assign out_task_count       = tcnt_r;
  assign out_short_count      = scnt_r;

endmodule

[hdl/class_aware_task_queue_unit.sv]
// Ordered task queue of 16 entries with short/long class-aware dequeue. Each transaction
// is accepted, then searched by class over the 16 occupancy and class bits, then applied:
// the chosen entry is read, the queue compacted and the output register loaded; the apply
// step waits while the previous result is still untaken. Program queue_limit at address 0
// over the APB port only while no transaction is in flight.
module class_aware_task_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctq_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic                                in_requester_is_short,
  input  logic [ctq_pkg::HANDLE_W-1:0]        in_conn_handle_in,
  input  logic [ctq_pkg::CODE_W-1:0]          in_command_code_in,
  input  logic [ctq_pkg::DESC_W-1:0]          in_descriptor_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [ctq_pkg::HANDLE_W-1:0]        out_conn_handle_out,
  output logic [ctq_pkg::CODE_W-1:0]          out_command_code_out,
  output logic [ctq_pkg::DESC_W-1:0]          out_descriptor_out,
  output logic [ctq_pkg::CNT_W-1:0]           out_task_count,
  output logic [ctq_pkg::CNT_W-1:0]           out_short_count
);

  logic [ctq_pkg::LIMIT_W-1:0] limit_r;
  logic                        cfg_wr;
  ctq_pkg::ctl_cmd_t           cmd;
  ctq_pkg::dp_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ctq_pkg::REG_QUEUE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ctq_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[ctq_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ctq_pkg::REG_QUEUE_LIMIT) ?
                  {{(32 - ctq_pkg::LIMIT_W){1'b0}}, limit_r} : '0;

  ctq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctq_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .queue_limit           (limit_r),
    .in_mode               (in_mode),
    .in_requester_is_short (in_requester_is_short),
    .in_conn_handle_in     (in_conn_handle_in),
    .in_command_code_in    (in_command_code_in),
    .in_descriptor_in      (in_descriptor_in),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_conn_handle_out   (out_conn_handle_out),
    .out_command_code_out  (out_command_code_out),
    .out_descriptor_out    (out_descriptor_out),
    .out_task_count        (out_task_count),
    .out_short_count       (out_short_count)
  );

  a_short_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_short_count <= out_task_count)
    else $error("short count exceeds task count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_task_count <= ctq_pkg::CNT_W'(ctq_pkg::DEPTH))
    else $error("task count exceeds depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ctq_pkg::ST_DONE) |->
      (out_conn_handle_out == '0 && out_command_code_out == '0 &&
       out_descriptor_out == '0))
    else $error("failed transaction carries a task");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

[bench/tb_class_aware_task_queue_unit.sv]
module tb_class_aware_task_queue_unit;

  localparam int IDLE_PCT = 23;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [ctq_pkg::PADDR_W-1:0] LIMIT_ADDR =
    ctq_pkg::PADDR_W'(4 * ctq_pkg::REG_QUEUE_LIMIT);
  localparam logic [ctq_pkg::PADDR_W-1:0] UNMAPPED_ADDR = ctq_pkg::PADDR_W'(4);

  typedef struct packed {
    logic                         mode;
    logic                         req_short;
    logic [ctq_pkg::HANDLE_W-1:0] handle;
    logic [ctq_pkg::CODE_W-1:0]   code;
    logic [ctq_pkg::DESC_W-1:0]   desc;
  } task_item_t;

  typedef struct packed {
    ctq_pkg::status_t             status;
    logic [ctq_pkg::HANDLE_W-1:0] handle;
    logic [ctq_pkg::CODE_W-1:0]   code;
    logic [ctq_pkg::DESC_W-1:0]   desc;
    logic [ctq_pkg::CNT_W-1:0]    tasks;
    logic [ctq_pkg::CNT_W-1:0]    shorts;
  } task_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ctq_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic in_requester_is_short = 1'b0;
  logic [ctq_pkg::HANDLE_W-1:0] in_conn_handle_in = '0;
  logic [ctq_pkg::CODE_W-1:0] in_command_code_in = '0;
  logic [ctq_pkg::DESC_W-1:0] in_descriptor_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [ctq_pkg::HANDLE_W-1:0] out_conn_handle_out;
  logic [ctq_pkg::CODE_W-1:0] out_command_code_out;
  logic [ctq_pkg::DESC_W-1:0] out_descriptor_out;
  logic [ctq_pkg::CNT_W-1:0] out_task_count;
  logic [ctq_pkg::CNT_W-1:0] out_short_count;

  task_item_t pending_items[$];
  task_result_t expected_results[$];
  task_item_t held_tasks[$];
  int unsigned short_held = 0;
  logic [ctq_pkg::LIMIT_W-1:0] limit_reg = ctq_pkg::LIMIT_RESET;

  logic in_taken = 1'b0;
  logic calm = 1'b0;
  logic send_hold = 1'b0;
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int n_enq = 0, n_full = 0, n_deq = 0, n_none = 0;

  class_aware_task_queue_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_requester_is_short(in_requester_is_short),
    .in_conn_handle_in(in_conn_handle_in), .in_command_code_in(in_command_code_in),
    .in_descriptor_in(in_descriptor_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_conn_handle_out(out_conn_handle_out), .out_command_code_out(out_command_code_out),
    .out_descriptor_out(out_descriptor_out), .out_task_count(out_task_count),
    .out_short_count(out_short_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_long_task(input logic [ctq_pkg::CODE_W-1:0] code);
    return (code == ctq_pkg::LONG_CODE_A) || (code == ctq_pkg::LONG_CODE_B);
  endfunction

  function automatic task_result_t apply_queue_op(input task_item_t op);
    task_result_t r;
    int pos;
    int eff_limit;
    r = '0;
    r.status = ctq_pkg::ST_DONE;
    eff_limit = (limit_reg > ctq_pkg::DEPTH) ? ctq_pkg::DEPTH : int'(limit_reg);
    if (op.mode == ctq_pkg::MODE_ENQUEUE) begin
      n_enq++;
      if (held_tasks.size() >= eff_limit) begin
        r.status = ctq_pkg::ST_FULL;
        n_full++;
      end else begin
        held_tasks.push_back(op);
        if (!is_long_task(op.code)) short_held++;
      end
    end else begin
      n_deq++;
      pos = -1;
      foreach (held_tasks[i]) begin
        if (pos < 0 && (is_long_task(held_tasks[i].code) != op.req_short)) pos = i;
      end
      if (pos < 0 && !op.req_short && held_tasks.size() > 0) pos = 0;
      if (pos < 0) begin
        r.status = ctq_pkg::ST_EMPTY;
        n_none++;
      end else begin
        r.handle = held_tasks[pos].handle;
        r.code = held_tasks[pos].code;
        r.desc = held_tasks[pos].desc;
        if (!is_long_task(r.code) && short_held > 0) short_held--;
        held_tasks.delete(pos);
      end
    end
    r.tasks = ctq_pkg::CNT_W'(held_tasks.size());
    r.shorts = ctq_pkg::CNT_W'(short_held);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("[class_aware_task_queue_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    task_result_t want;
    task_item_t seen;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
        limit_reg = pwdata[ctq_pkg::LIMIT_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, status %0d handle %h", $time, out_status,
                   out_conn_handle_out);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("conn_handle", 64'(want.handle), 64'(out_conn_handle_out));
          check_field("command_code", 64'(want.code), 64'(out_command_code_out));
          check_field("descriptor", want.desc, out_descriptor_out);
          check_field("task_count", 64'(want.tasks), 64'(out_task_count));
          check_field("short_count", 64'(want.shorts), 64'(out_short_count));
        end
      end
      if (in_valid && in_ready) begin
        seen = {in_mode, in_requester_is_short, in_conn_handle_in, in_command_code_in,
                in_descriptor_in};
        expected_results.push_back(apply_queue_op(seen));
      end
    end
  end

  always @(negedge clk) begin : driver
    task_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!in_valid || in_taken) begin
        if (pending_items.size() > 0 && !send_hold &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_requester_is_short <= nxt.req_short;
          in_conn_handle_in <= nxt.handle;
          in_command_code_in <= nxt.code;
          in_descriptor_in <= nxt.desc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic task_item_t enq_item(input logic [ctq_pkg::HANDLE_W-1:0] handle,
                                          input logic [ctq_pkg::CODE_W-1:0] code,
                                          input logic [ctq_pkg::DESC_W-1:0] desc);
    task_item_t it;
    it.mode = ctq_pkg::MODE_ENQUEUE;
    it.req_short = 1'($urandom);
    it.handle = handle;
    it.code = code;
    it.desc = desc;
    return it;
  endfunction

  function automatic task_item_t deq_item(input logic req_short);
    task_item_t it;
    it.mode = ctq_pkg::MODE_DEQUEUE;
    it.req_short = req_short;
    it.handle = ctq_pkg::HANDLE_W'($urandom);
    it.code = ctq_pkg::CODE_W'($urandom);
    it.desc = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [ctq_pkg::CODE_W-1:0] random_code();
    if ($urandom_range(0, 99) < 35) begin
      return $urandom_range(0, 1) ? ctq_pkg::LONG_CODE_A : ctq_pkg::LONG_CODE_B;
    end
    return ctq_pkg::CODE_W'($urandom);
  endfunction

  task automatic add_random(input int count);
    int enq_pct;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 75;
        endcase
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        pending_items.push_back(enq_item(ctq_pkg::HANDLE_W'($urandom), random_code(),
                                         {$urandom, $urandom}));
      end else begin
        pending_items.push_back(deq_item(1'($urandom)));
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [ctq_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(input logic [ctq_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    logic [31:0] rd;
    cfg_access(1'b1, addr, data, rd);
    cfg_access(1'b0, LIMIT_ADDR, 32'd0, rd);
    check_field("queue_limit readback", 64'(limit_reg),
                64'(rd[ctq_pkg::LIMIT_W-1:0]));
  endtask

  task automatic random_phase(input logic [ctq_pkg::LIMIT_W-1:0] limit, input int count,
                              input logic quiet, input logic hold_mid);
    write_reg(LIMIT_ADDR, {27'($urandom), limit});
    @(posedge clk);
    calm = quiet;
    add_random(count);
    if (hold_mid) begin
      do @(posedge clk);
      while (pending_items.size() > count / 2);
      send_hold = 1'b1;
      do @(posedge clk);
      while (in_valid || expected_results.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
      send_hold = 1'b0;
    end
    wait_quiet();
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    pending_items.push_back(deq_item(1'b0));
    pending_items.push_back(deq_item(1'b1));
    pending_items.push_back(enq_item(16'h0000, ctq_pkg::LONG_CODE_A, 64'h0));
    pending_items.push_back(deq_item(1'b1));
    pending_items.push_back(enq_item(16'hFFFF, 8'hFF, {ctq_pkg::DESC_W{1'b1}}));
    pending_items.push_back(enq_item(16'h1234, ctq_pkg::LONG_CODE_B,
                                     64'h8000_0000_0000_0001));
    pending_items.push_back(enq_item(16'h0001, 8'h00, 64'h0123_4567_89AB_CDEF));
    pending_items.push_back(enq_item(16'h8000, 8'h04, 64'hFEDC_BA98_7654_3210));
    pending_items.push_back(deq_item(1'b0));
    pending_items.push_back(deq_item(1'b1));
    pending_items.push_back(deq_item(1'b0));
    pending_items.push_back(deq_item(1'b0));
    pending_items.push_back(deq_item(1'b0));
    wait_quiet();

    write_reg(LIMIT_ADDR, 32'd2);
    pending_items.push_back(enq_item(16'h00AA, 8'h07, 64'h5555_5555_5555_5555));
    pending_items.push_back(enq_item(16'h0055, ctq_pkg::LONG_CODE_A,
                                     64'hAAAA_AAAA_AAAA_AAAA));
    pending_items.push_back(enq_item(16'h0F0F, 8'h80, 64'h1));
    pending_items.push_back(deq_item(1'b1));
    pending_items.push_back(deq_item(1'b1));
    wait_quiet();

    write_reg(LIMIT_ADDR, 32'd0);
    pending_items.push_back(enq_item(16'h7FFF, 8'h01, 64'h2));
    pending_items.push_back(deq_item(1'b0));
    pending_items.push_back(deq_item(1'b0));
    wait_quiet();

    write_reg(UNMAPPED_ADDR, 32'd3);

    random_phase(5'd31, 400, 1'b0, 1'b0);
    random_phase(5'd1, 200, 1'b0, 1'b0);
    random_phase(5'd16, 300, 1'b1, 1'b0);
    random_phase(ctq_pkg::LIMIT_W'($urandom_range(2, 15)), 300, 1'b0, 1'b1);
    random_phase(5'd0, 100, 1'b0, 1'b0);
    random_phase(5'd16, 400, 1'b0, 1'b0);

    $display("ran %0d enqueues (%0d refused as full) and %0d dequeues (%0d found nothing)",
             n_enq, n_full, n_deq, n_none);
    $display("checked %0d results over queue limits 0, 1, 2, 16, 31 and one random limit",
             results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[class_aware_task_queue_unit] OK");
    end else begin
      $display("[class_aware_task_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ctq_pkg.sv
hdl/ctq_ctrl.sv
hdl/ctq_datapath.sv
hdl/class_aware_task_queue_unit.sv
bench/tb_class_aware_task_queue_unit.sv
